/* design/lkv_pkg.sv */
package lkv_pkg;

	localparam int DEF_ENTRIES = 16;

	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// register index, decoded from paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic KIND_PUT = 1'b0;
	localparam logic KIND_GET = 1'b1;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] key;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic load_in;
		logic lookup;
		logic commit;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_get;
	} sts_t;

endpackage

/* design/lkv_ctrl.sv */
module lkv_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  lkv_pkg::sts_t sts,
	output lkv_pkg::cmd_t cmd
);
	import lkv_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   done_ok;
	logic   accept;

	// a get may not overwrite a result that is still held
	assign done_ok  = !(sts.is_get && out_valid_q && out_stall);
	assign in_stall = !((state_q == ST_IDLE) || ((state_q == ST_UPD) && done_ok));
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd.load_in  = accept;
		cmd.lookup   = (state_q == ST_LOOK);
		cmd.commit   = (state_q == ST_UPD) && done_ok;
		cmd.load_out = (state_q == ST_UPD) && done_ok && sts.is_get;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_nxt = ST_LOOK;
			end
			ST_LOOK: begin
				state_nxt = ST_UPD;
			end
			ST_UPD: begin
				if (done_ok) state_nxt = accept ? ST_LOOK : ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && out_stall))
		else $error("held result overwritten");

	a_accept_to_look: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_LOOK))
		else $error("accepted transaction not looked up");

	a_look_to_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) |=> (state_q == ST_UPD))
		else $error("lookup not followed by update");

endmodule

/* design/lkv_dp.sv */
module lkv_dp #(
	parameter int ENTRIES = lkv_pkg::DEF_ENTRIES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lkv_pkg::req_t              in_data,
	input  logic [$clog2(ENTRIES)-1:0] cap_m1,
	input  lkv_pkg::cmd_t              cmd,
	output lkv_pkg::sts_t              sts,
	output lkv_pkg::rsp_t              out_data
);
	import lkv_pkg::*;

	localparam int RW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	req_t                in_q;
	logic [31:0]         key_q   [ENTRIES];
	logic [31:0]         val_q   [ENTRIES];
	logic [RW-1:0]       rank_q  [ENTRIES];
	logic [ENTRIES-1:0]  valid_q;
	logic [CW-1:0]       count_q;
	rsp_t                out_q;

	logic [ENTRIES-1:0]  match;
	logic [ENTRIES-1:0]  kill;
	logic                hit;
	logic                over;
	logic [RW-1:0]       hit_rank;
	logic [31:0]         rd_val;

	logic [ENTRIES-1:0]  match_s1;
	logic [ENTRIES-1:0]  kill_s1;
	logic                hit_s1;
	logic                over_s1;
	logic [RW-1:0]       hit_rank_s1;
	logic [31:0]         rd_val_s1;

	logic [ENTRIES-1:0]  remain;
	logic [ENTRIES-1:0]  free_oh;
	logic                insert;
	logic                is_put;

	assign sts.is_get = (in_q.kind == KIND_GET);
	assign is_put     = (in_q.kind == KIND_PUT);

	// compare all entries at once; mark what an insert would evict
	always_comb begin
		over     = count_q > CW'(cap_m1);
		hit_rank = '0;
		rd_val   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == in_q.key);
			kill[i]  = over && valid_q[i] && (rank_q[i] >= cap_m1);
			hit_rank = hit_rank | (match[i] ? rank_q[i] : '0);
			rd_val   = rd_val | (match[i] ? val_q[i] : '0);
		end
		hit = |match;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q <= in_data;
		end
		if (cmd.lookup) begin
			match_s1    <= match;
			kill_s1     <= kill;
			hit_s1      <= hit;
			over_s1     <= over;
			hit_rank_s1 <= hit_rank;
			rd_val_s1   <= rd_val;
		end
		if (cmd.load_out) begin
			out_q.hit        <= hit_s1;
			out_q.read_value <= rd_val_s1;
		end
	end

	// lowest free slot after eviction
	assign remain  = valid_q & ~kill_s1;
	assign free_oh = ~remain & (remain + ENTRIES'(1));
	assign insert  = !hit_s1 && is_put;

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (cmd.commit) begin
				if (hit_s1) begin
					if (match_s1[i]) begin
						rank_q[i] <= '0;
						if (is_put) val_q[i] <= in_q.value;
					end else if (valid_q[i] && (rank_q[i] < hit_rank_s1)) begin
						rank_q[i] <= RW'(rank_q[i] + 1'b1);
					end
				end else if (insert) begin
					if (free_oh[i]) begin
						key_q[i]  <= in_q.key;
						val_q[i]  <= in_q.value;
						rank_q[i] <= '0;
					end else if (remain[i]) begin
						rank_q[i] <= RW'(rank_q[i] + 1'b1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.commit && insert) begin
			valid_q <= remain | free_oh;
			count_q <= over_s1 ? CW'(CW'(cap_m1) + CW'(1)) : CW'(count_q + CW'(1));
		end
	end

	assign out_data = out_q;

endmodule

/* design/lru_key_value_cache_unit.sv */
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / in_stall   | in_data (kind, key, value)
// out     | output    | out_valid / out_stall | out_data (hit, read_value)
// apb     | input     | psel/penable/pready  | paddr, pwdata, prdata (capacity)
//
// A transaction has a lookup step that compares the key against every entry
// in parallel, then an update step for values and recency ranks. A new transaction is
// accepted in the update cycle of the previous one.
// Reset clears the valid bits and entry count and sets capacity to 16.
// A get waits in its update cycle while an earlier result is still held.
// A put produces no result and never waits on the output side.
module lru_key_value_cache_unit #(
	parameter int ENTRIES = lkv_pkg::DEF_ENTRIES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  lkv_pkg::req_t               in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output lkv_pkg::rsp_t               out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lkv_pkg::APB_AW-1:0]  paddr,
	input  logic [lkv_pkg::APB_DW-1:0]  pwdata,
	output logic [lkv_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import lkv_pkg::*;

	localparam int RW = $clog2(ENTRIES);

	logic [CAP_W-1:0] cap_q;
	logic [RW-1:0]    cap_m1;
	logic             reg_sel;
	cmd_t             cmd;
	sts_t             sts;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = reg_sel ? APB_DW'(cap_q) : '0;

	// effective capacity minus one: zero acts as one, clamp at ENTRIES
	always_comb begin
		if (cap_q == '0) begin
			cap_m1 = '0;
		end else if (32'(cap_q) >= ENTRIES) begin
			cap_m1 = RW'(ENTRIES - 1);
		end else begin
			cap_m1 = RW'(cap_q - 1'b1);
		end
	end

	lkv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lkv_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cap_m1   (cap_m1),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

endmodule
